>>> hdl/cbm_pkg.sv
// cbm_pkg: shared types and codes for the cartridge bank mapper
// bus event kinds, memory targets, command codes, register indexes
// no dependencies
package cbm_pkg;

   typedef enum logic [2:0] {
      MODE_CPU_READ  = 3'd0,
      MODE_CPU_WRITE = 3'd1,
      MODE_PPU_READ  = 3'd2,
      MODE_PPU_WRITE = 3'd3,
      MODE_TICK      = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      TGT_NONE    = 3'd0,
      TGT_PRG_ROM = 3'd1,
      TGT_PRG_RAM = 3'd2,
      TGT_CHR_ROM = 3'd3,
      TGT_CHR_RAM = 3'd4
   } target_type;

   typedef enum logic [1:0] {
      CSR_PRG_ROM_MASK = 2'd0,
      CSR_CHR_MASK     = 2'd1,
      CSR_CHR_IS_RAM   = 2'd2,
      CSR_PRG_RAM_LOG2 = 2'd3
   } csr_index_type;

   localparam logic [3:0] CMD_WINDOW    = 4'h8;
   localparam logic [3:0] CMD_PRG_FIRST = 4'h9;
   localparam logic [3:0] CMD_PRG_LAST  = 4'hB;
   localparam logic [3:0] CMD_MIRROR    = 4'hC;
   localparam logic [3:0] CMD_IRQ_CTRL  = 4'hD;
   localparam logic [3:0] CMD_COUNT_LO  = 4'hE;
   localparam logic [3:0] CMD_COUNT_HI  = 4'hF;

   localparam logic [5:0] FIXED_PRG_BANK = 6'h3F;
   localparam logic [4:0] RAM_LOG2_MAX   = 5'd19;

   localparam int ADDR_BITS = 19;

   typedef struct packed {
      logic [5:0] prg_rom_bank_mask;
      logic [7:0] chr_bank_mask;
      logic       chr_is_ram;
      logic [4:0] prg_ram_size_log2;
   } cfg_type;

   typedef struct packed {
      target_type             target;
      logic [ADDR_BITS-1:0]   address;
      logic                   write;
      logic                   read_zero;
   } map_result_type;

endpackage

>>> hdl/cbm_state.sv
// cbm_state: mapper command registers, bank registers and irq counter
// updated by cpu writes and ticks; depends on cbm_pkg
module cbm_state #(
   parameter int PRG_BANK_BITS = 6,
   parameter int CHR_BANK_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [2:0]               mode,
   input  logic [15:0]              bus_address,
   input  logic [7:0]               write_data,
   output logic [CHR_BANK_BITS-1:0] chr_bank [8],
   output logic [PRG_BANK_BITS-1:0] prg_bank [3],
   output logic [7:0]               window_control,
   output logic [1:0]               mirror_next,
   output logic                     irq_next
);

   logic [3:0]               command_select_ff, command_select_in;
   logic [CHR_BANK_BITS-1:0] chr_bank_ff [8];
   logic [CHR_BANK_BITS-1:0] chr_bank_in [8];
   logic [PRG_BANK_BITS-1:0] prg_bank_ff [3];
   logic [PRG_BANK_BITS-1:0] prg_bank_in [3];
   logic [7:0]               window_ff, window_in;
   logic [1:0]               mirror_ff, mirror_in;
   logic                     irq_enable_ff, irq_enable_in;
   logic                     counter_enable_ff, counter_enable_in;
   logic                     pending_ff, pending_in;
   logic [15:0]              count_ff, count_in;
   logic                     reg_write;
   logic [1:0]               prg_index;

   assign reg_write = fire && (mode == cbm_pkg::MODE_CPU_WRITE) && bus_address[15];
   assign prg_index = 2'(command_select_ff - cbm_pkg::CMD_PRG_FIRST);

   always_comb begin
      command_select_in = command_select_ff;
      chr_bank_in       = chr_bank_ff;
      prg_bank_in       = prg_bank_ff;
      window_in         = window_ff;
      mirror_in         = mirror_ff;
      irq_enable_in     = irq_enable_ff;
      counter_enable_in = counter_enable_ff;
      pending_in        = pending_ff;
      count_in          = count_ff;
      if (reg_write && (bus_address[14:13] == 2'b00)) begin
         command_select_in = write_data[3:0];
      end else if (reg_write && (bus_address[14:13] == 2'b01)) begin
         priority if (command_select_ff < cbm_pkg::CMD_WINDOW) begin
            chr_bank_in[command_select_ff[2:0]] = CHR_BANK_BITS'(write_data);
         end else if (command_select_ff == cbm_pkg::CMD_WINDOW) begin
            window_in = write_data;
         end else if (command_select_ff <= cbm_pkg::CMD_PRG_LAST) begin
            prg_bank_in[prg_index] = PRG_BANK_BITS'(write_data[5:0]);
         end else if (command_select_ff == cbm_pkg::CMD_MIRROR) begin
            mirror_in = write_data[1:0];
         end else if (command_select_ff == cbm_pkg::CMD_IRQ_CTRL) begin
            pending_in        = 1'b0;
            irq_enable_in     = write_data[0];
            counter_enable_in = write_data[7];
         end else if (command_select_ff == cbm_pkg::CMD_COUNT_LO) begin
            count_in = {count_ff[15:8], write_data};
         end else begin
            count_in = {write_data, count_ff[7:0]};
         end
      end else if (fire && (mode == cbm_pkg::MODE_TICK) && counter_enable_ff) begin
         count_in = count_ff - 16'd1;
         if ((count_ff == 16'd0) && irq_enable_ff) begin
            pending_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_select_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            chr_bank_ff[i] <= CHR_BANK_BITS'(i);
         end
         for (int i = 0; i < 3; i++) begin
            prg_bank_ff[i] <= PRG_BANK_BITS'(i);
         end
         window_ff         <= '0;
         mirror_ff         <= '0;
         irq_enable_ff     <= 1'b0;
         counter_enable_ff <= 1'b0;
         pending_ff        <= 1'b0;
         count_ff          <= '0;
      end else begin
         command_select_ff <= command_select_in;
         chr_bank_ff       <= chr_bank_in;
         prg_bank_ff       <= prg_bank_in;
         window_ff         <= window_in;
         mirror_ff         <= mirror_in;
         irq_enable_ff     <= irq_enable_in;
         counter_enable_ff <= counter_enable_in;
         pending_ff        <= pending_in;
         count_ff          <= count_in;
      end
   end

   assign chr_bank       = chr_bank_ff;
   assign prg_bank       = prg_bank_ff;
   assign window_control = window_ff;
   assign mirror_next    = mirror_in;
   assign irq_next       = pending_in;

endmodule

>>> hdl/cbm_map.sv
// cbm_map: translates one bus word into target memory, address and write strobe
// combinational; depends on cbm_pkg
module cbm_map #(
   parameter int PRG_BANK_BITS = 6,
   parameter int CHR_BANK_BITS = 8
) (
   input  logic [2:0]                 mode,
   input  logic [15:0]                bus_address,
   input  cbm_pkg::cfg_type           cfg,
   input  logic [CHR_BANK_BITS-1:0]   chr_bank [8],
   input  logic [PRG_BANK_BITS-1:0]   prg_bank [3],
   input  logic [7:0]                 window_control,
   output cbm_pkg::map_result_type    result
);

   logic                           is_write;
   logic [5:0]                     win_bank;
   logic [5:0]                     slot_bank;
   logic [7:0]                     slot_wide;
   logic [7:0]                     chr_sel;
   logic [cbm_pkg::ADDR_BITS-1:0]  ram_mask;
   logic [4:0]                     ram_log2;

   assign is_write = (mode == cbm_pkg::MODE_CPU_WRITE);
   assign win_bank = window_control[5:0];
   assign ram_log2 = (cfg.prg_ram_size_log2 > cbm_pkg::RAM_LOG2_MAX) ?
                     cbm_pkg::RAM_LOG2_MAX : cfg.prg_ram_size_log2;
   assign ram_mask = ~({cbm_pkg::ADDR_BITS{1'b1}} << ram_log2);
   assign chr_sel  = 8'(chr_bank[bus_address[12:10]]) & cfg.chr_bank_mask;

   always_comb begin
      unique case (bus_address[14:13])
         2'd0:    slot_wide = 8'(prg_bank[0]);
         2'd1:    slot_wide = 8'(prg_bank[1]);
         2'd2:    slot_wide = 8'(prg_bank[2]);
         default: slot_wide = {2'b00, cbm_pkg::FIXED_PRG_BANK};
      endcase
      slot_bank = slot_wide[5:0];
   end

   always_comb begin
      result.target    = cbm_pkg::TGT_NONE;
      result.address   = '0;
      result.write     = 1'b0;
      result.read_zero = 1'b0;
      case (mode)
         cbm_pkg::MODE_CPU_READ, cbm_pkg::MODE_CPU_WRITE: begin
            if (bus_address[15:13] == 3'b011) begin
               if (window_control[6]) begin
                  if (window_control[7] && (cfg.prg_ram_size_log2 != 5'd0)) begin
                     result.target  = cbm_pkg::TGT_PRG_RAM;
                     result.address = {win_bank, bus_address[12:0]} & ram_mask;
                     result.write   = is_write;
                  end else if (!is_write) begin
                     result.read_zero = 1'b1;
                  end
               end else if (!is_write) begin
                  result.target  = cbm_pkg::TGT_PRG_ROM;
                  result.address = {win_bank & cfg.prg_rom_bank_mask, bus_address[12:0]};
               end
            end else if (bus_address[15] && !is_write) begin
               result.target  = cbm_pkg::TGT_PRG_ROM;
               result.address = {slot_bank & cfg.prg_rom_bank_mask, bus_address[12:0]};
            end
         end
         cbm_pkg::MODE_PPU_READ, cbm_pkg::MODE_PPU_WRITE: begin
            if (bus_address[15:13] == 3'b000) begin
               if (cfg.chr_is_ram) begin
                  result.target  = cbm_pkg::TGT_CHR_RAM;
                  result.address = {1'b0, chr_sel, bus_address[9:0]};
                  result.write   = (mode == cbm_pkg::MODE_PPU_WRITE);
               end else if (mode == cbm_pkg::MODE_PPU_READ) begin
                  result.target  = cbm_pkg::TGT_CHR_ROM;
                  result.address = {1'b0, chr_sel, bus_address[9:0]};
               end
            end
         end
         default: begin
            result.target = cbm_pkg::TGT_NONE;
         end
      endcase
   end

endmodule

>>> hdl/cartridge_bank_mapper_with_irq_core.sv
// cartridge_bank_mapper_with_irq_core: top level of the cartridge bank mapper
// request register, mapper state, address map and response register
// depends on cbm_pkg, cbm_state, cbm_map
//
// usage:
//   req_* carries one bus word per handshake: a cpu read or write, a ppu read
//   or write, or a cpu cycle tick. rsp_* returns exactly one word per request
//   with the target memory, byte address, write strobe, zero-read flag, the
//   irq line and the mirroring as they stand after that request.
//   csr_* writes the size registers (prg rom mask, chr mask, chr ram flag,
//   prg ram size); write them only while no request is in flight.
// path: accepted words pass the request register, then the response register.
// throughput: 1 word per cycle while rsp_ready is high; request register and
//   response register form a two-stage pipeline; state is read and updated in
//   the single mapping stage, so back-to-back words see each other's effects.
// reset: synchronous; banks reset to identity, irq and counter cleared,
//   size registers to 63, 255, 0, 13; pipeline empties.
// stall: when rsp_ready is low the response holds, the request stage keeps
//   its word, and req_ready drops once both stages are full.
module cartridge_bank_mapper_with_irq_core #(
   parameter int PRG_BANK_BITS = 6,
   parameter int CHR_BANK_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_mem_target,
   output logic [18:0] rsp_mem_address,
   output logic        rsp_mem_write,
   output logic        rsp_read_zero,
   output logic        rsp_irq_line,
   output logic [1:0]  rsp_mirroring,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   cbm_pkg::cfg_type        cfg_ff, cfg_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic [2:0]              s1_mode_ff;
   logic [15:0]             s1_address_ff;
   logic [7:0]              s1_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   cbm_pkg::map_result_type rsp_map_ff;
   logic                    rsp_irq_ff;
   logic [1:0]              rsp_mirror_ff;
   logic                    advance;
   logic                    accept;
   logic [CHR_BANK_BITS-1:0] chr_bank [8];
   logic [PRG_BANK_BITS-1:0] prg_bank [3];
   logic [7:0]              window_control;
   logic [1:0]              mirror_next;
   logic                    irq_next;
   cbm_pkg::map_result_type map_result;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (cbm_pkg::csr_index_type'(csr_index))
            cbm_pkg::CSR_PRG_ROM_MASK: cfg_in.prg_rom_bank_mask = csr_write_data[5:0];
            cbm_pkg::CSR_CHR_MASK:     cfg_in.chr_bank_mask     = csr_write_data;
            cbm_pkg::CSR_CHR_IS_RAM:   cfg_in.chr_is_ram        = csr_write_data[0];
            cbm_pkg::CSR_PRG_RAM_LOG2: cfg_in.prg_ram_size_log2 = csr_write_data[4:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prg_rom_bank_mask <= 6'd63;
         cfg_ff.chr_bank_mask     <= 8'd255;
         cfg_ff.chr_is_ram        <= 1'b0;
         cfg_ff.prg_ram_size_log2 <= 5'd13;
         s1_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff    <= req_mode;
         s1_address_ff <= req_bus_address;
         s1_data_ff    <= req_write_data;
      end
      if (advance) begin
         rsp_map_ff    <= map_result;
         rsp_irq_ff    <= irq_next;
         rsp_mirror_ff <= mirror_next;
      end
   end

   cbm_state #(
      .PRG_BANK_BITS (PRG_BANK_BITS),
      .CHR_BANK_BITS (CHR_BANK_BITS)
   ) u_state (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .mode           (s1_mode_ff),
      .bus_address    (s1_address_ff),
      .write_data     (s1_data_ff),
      .chr_bank       (chr_bank),
      .prg_bank       (prg_bank),
      .window_control (window_control),
      .mirror_next    (mirror_next),
      .irq_next       (irq_next)
   );

   cbm_map #(
      .PRG_BANK_BITS (PRG_BANK_BITS),
      .CHR_BANK_BITS (CHR_BANK_BITS)
   ) u_map (
      .mode           (s1_mode_ff),
      .bus_address    (s1_address_ff),
      .cfg            (cfg_ff),
      .chr_bank       (chr_bank),
      .prg_bank       (prg_bank),
      .window_control (window_control),
      .result         (map_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mem_target  = rsp_map_ff.target;
   assign rsp_mem_address = rsp_map_ff.address;
   assign rsp_mem_write   = rsp_map_ff.write;
   assign rsp_read_zero   = rsp_map_ff.read_zero;
   assign rsp_irq_line    = rsp_irq_ff;
   assign rsp_mirroring   = rsp_mirror_ff;

endmodule

>>> hdl/cbm_checker.sv
// cbm_checker: port-level checks on the mapper response channel
// bound to cartridge_bank_mapper_with_irq_core; depends on cbm_pkg
module cbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_mem_target,
   input logic [18:0] rsp_mem_address,
   input logic        rsp_mem_write,
   input logic        rsp_read_zero
);

   // response word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mem_target)
         && $stable(rsp_mem_address) && $stable(rsp_mem_write))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_none_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mem_target == cbm_pkg::TGT_NONE) |->
         (rsp_mem_address == '0) && !rsp_mem_write)
      else $error("no target but address or write set");

   a_write_ram: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_write |->
         (rsp_mem_target == cbm_pkg::TGT_PRG_RAM) || (rsp_mem_target == cbm_pkg::TGT_CHR_RAM))
      else $error("write strobe on a read-only target");

   a_zero_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_zero |-> (rsp_mem_target == cbm_pkg::TGT_NONE))
      else $error("zero read with a target");

endmodule

bind cartridge_bank_mapper_with_irq_core cbm_checker u_cbm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_mem_target  (rsp_mem_target),
   .rsp_mem_address (rsp_mem_address),
   .rsp_mem_write   (rsp_mem_write),
   .rsp_read_zero   (rsp_read_zero)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for cartridge_bank_mapper_with_irq_core
// runs a directed table, then random command/load/access sequences under several size settings,
// checks each word against its table row or an in-bench model; depends on cbm_pkg and the core
module tb;

   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          HOLD_CYCLES     = 80;
   localparam int          PHASE_WORDS     = 120;
   localparam logic [2:0]  MODE_UNUSED     = 3'd7;
   localparam logic [1:0]  MIRROR_VERTICAL = 2'd0;

   typedef struct packed {
      cbm_pkg::target_type target;
      logic [18:0]         address;
      logic                write;
      logic                read_zero;
      logic                irq;
      logic [1:0]          mirroring;
   } word_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] address;
      logic [7:0]  data;
      logic        fixed;
      word_type    want;
   } script_row_type;

   localparam word_type QUIET = '{cbm_pkg::TGT_NONE, 19'h0, 1'b0, 1'b0, 1'b0, MIRROR_VERTICAL};

   localparam int SCRIPT_ROWS = 27;
   script_row_type script [SCRIPT_ROWS] = '{
      '{cbm_pkg::MODE_CPU_READ,  16'h8000, 8'h00, 1'b1,
        '{cbm_pkg::TGT_PRG_ROM, 19'h00000, 1'b0, 1'b0, 1'b0, MIRROR_VERTICAL}},
      '{cbm_pkg::MODE_CPU_READ,  16'hA000, 8'hFF, 1'b1,
        '{cbm_pkg::TGT_PRG_ROM, 19'h02000, 1'b0, 1'b0, 1'b0, MIRROR_VERTICAL}},
      '{cbm_pkg::MODE_CPU_READ,  16'hFFFF, 8'hFF, 1'b1,
        '{cbm_pkg::TGT_PRG_ROM, 19'h7FFFF, 1'b0, 1'b0, 1'b0, MIRROR_VERTICAL}},
      '{cbm_pkg::MODE_CPU_READ,  16'h6000, 8'h00, 1'b1,
        '{cbm_pkg::TGT_PRG_ROM, 19'h00000, 1'b0, 1'b0, 1'b0, MIRROR_VERTICAL}},
      '{cbm_pkg::MODE_CPU_WRITE, 16'h7FFF, 8'hFF, 1'b1, QUIET},
      '{cbm_pkg::MODE_CPU_READ,  16'h0000, 8'h00, 1'b1, QUIET},
      '{cbm_pkg::MODE_PPU_READ,  16'h0000, 8'h00, 1'b1,
        '{cbm_pkg::TGT_CHR_ROM, 19'h00000, 1'b0, 1'b0, 1'b0, MIRROR_VERTICAL}},
      '{cbm_pkg::MODE_PPU_READ,  16'h1FFF, 8'h00, 1'b1,
        '{cbm_pkg::TGT_CHR_ROM, 19'h01FFF, 1'b0, 1'b0, 1'b0, MIRROR_VERTICAL}},
      '{cbm_pkg::MODE_PPU_WRITE, 16'h0400, 8'hFF, 1'b1, QUIET},
      '{cbm_pkg::MODE_PPU_READ,  16'hFFFF, 8'h00, 1'b1, QUIET},
      '{cbm_pkg::MODE_TICK,      16'h0000, 8'h00, 1'b1, QUIET},
      '{MODE_UNUSED,             16'hFFFF, 8'hFF, 1'b1, QUIET},
      '{cbm_pkg::MODE_CPU_WRITE, 16'h8000, {4'h0, cbm_pkg::CMD_WINDOW}, 1'b0, QUIET},
      '{cbm_pkg::MODE_CPU_WRITE, 16'hBFFF, 8'h40, 1'b0, QUIET},
      '{cbm_pkg::MODE_CPU_READ,  16'h6123, 8'h00, 1'b1,
        '{cbm_pkg::TGT_NONE, 19'h00000, 1'b0, 1'b1, 1'b0, MIRROR_VERTICAL}},
      '{cbm_pkg::MODE_CPU_WRITE, 16'hA000, 8'hC1, 1'b0, QUIET},
      '{cbm_pkg::MODE_CPU_WRITE, 16'h7FFF, 8'h5A, 1'b0, QUIET},
      '{cbm_pkg::MODE_CPU_READ,  16'h6000, 8'h00, 1'b0, QUIET},
      '{cbm_pkg::MODE_CPU_WRITE, 16'h9FFF, {4'hF, cbm_pkg::CMD_MIRROR}, 1'b0, QUIET},
      '{cbm_pkg::MODE_CPU_WRITE, 16'hA000, 8'h03, 1'b0, QUIET},
      '{cbm_pkg::MODE_CPU_WRITE, 16'h8000, {4'h0, cbm_pkg::CMD_COUNT_LO}, 1'b0, QUIET},
      '{cbm_pkg::MODE_CPU_WRITE, 16'hA000, 8'h01, 1'b0, QUIET},
      '{cbm_pkg::MODE_CPU_WRITE, 16'h8000, {4'h0, cbm_pkg::CMD_IRQ_CTRL}, 1'b0, QUIET},
      '{cbm_pkg::MODE_CPU_WRITE, 16'hA000, 8'h81, 1'b0, QUIET},
      '{cbm_pkg::MODE_TICK,      16'h0000, 8'h00, 1'b0, QUIET},
      '{cbm_pkg::MODE_TICK,      16'h0000, 8'h00, 1'b0, QUIET},
      '{cbm_pkg::MODE_CPU_WRITE, 16'hC000, 8'hFF, 1'b0, QUIET}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = '0;
   logic [15:0] req_bus_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_mem_target;
   logic [18:0] rsp_mem_address;
   logic        rsp_mem_write;
   logic        rsp_read_zero;
   logic        rsp_irq_line;
   logic [1:0]  rsp_mirroring;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_write_data = '0;

   logic        row_fixed = 1'b0;
   word_type    row_want = QUIET;

   // mapper model state and size registers
   logic [5:0]  cfg_prg_mask;
   logic [7:0]  cfg_chr_mask;
   logic        cfg_chr_ram;
   logic [4:0]  cfg_ram_log2;
   logic [3:0]  cmd_sel;
   logic [7:0]  chr_bk [8];
   logic [5:0]  prg_bk [3];
   logic [7:0]  win_ctl;
   logic [1:0]  mirror;
   logic        irq_en;
   logic        cnt_en;
   logic        irq_pend;
   logic [15:0] irq_cnt;

   word_type    pending_words [$];
   int          mismatches = 0;
   int          words_checked = 0;
   int          irq_words = 0;
   int          settings_run = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_left = 0;
   logic        hold_request = 1'b0;

   cartridge_bank_mapper_with_irq_core dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   task automatic reset_mapper_model();
      cfg_prg_mask = 6'd63;
      cfg_chr_mask = 8'd255;
      cfg_chr_ram  = 1'b0;
      cfg_ram_log2 = 5'd13;
      cmd_sel      = '0;
      for (int i = 0; i < 8; i++) chr_bk[i] = 8'(i);
      for (int i = 0; i < 3; i++) prg_bk[i] = 6'(i);
      win_ctl  = '0;
      mirror   = MIRROR_VERTICAL;
      irq_en   = 1'b0;
      cnt_en   = 1'b0;
      irq_pend = 1'b0;
      irq_cnt  = '0;
   endtask

   task automatic load_command(input logic [7:0] d);
      if (cmd_sel < cbm_pkg::CMD_WINDOW) begin
         chr_bk[cmd_sel[2:0]] = d;
      end else if (cmd_sel == cbm_pkg::CMD_WINDOW) begin
         win_ctl = d;
      end else if (cmd_sel <= cbm_pkg::CMD_PRG_LAST) begin
         prg_bk[2'(cmd_sel - cbm_pkg::CMD_PRG_FIRST)] = d[5:0];
      end else if (cmd_sel == cbm_pkg::CMD_MIRROR) begin
         mirror = d[1:0];
      end else if (cmd_sel == cbm_pkg::CMD_IRQ_CTRL) begin
         irq_pend = 1'b0;
         irq_en   = d[0];
         cnt_en   = d[7];
      end else if (cmd_sel == cbm_pkg::CMD_COUNT_LO) begin
         irq_cnt[7:0] = d;
      end else begin
         irq_cnt[15:8] = d;
      end
   endtask

   task automatic map_bus_event(input logic [2:0] m, input logic [15:0] a,
                                input logic [7:0] d, output word_type r);
      logic        is_wr;
      logic [5:0]  bank;
      logic [7:0]  cbank;
      logic [4:0]  lg;
      logic [19:0] rmask;
      logic [15:0] prev;
      r = QUIET;
      case (m)
         cbm_pkg::MODE_CPU_READ, cbm_pkg::MODE_CPU_WRITE: begin
            is_wr = (m == cbm_pkg::MODE_CPU_WRITE);
            if (a >= 16'h6000 && a < 16'h8000) begin
               bank = win_ctl[5:0];
               if (win_ctl[6]) begin
                  if (win_ctl[7] && cfg_ram_log2 != 0) begin
                     lg = (cfg_ram_log2 > cbm_pkg::RAM_LOG2_MAX) ?
                          cbm_pkg::RAM_LOG2_MAX : cfg_ram_log2;
                     rmask = (20'd1 << lg) - 20'd1;
                     r.target  = cbm_pkg::TGT_PRG_RAM;
                     r.address = {bank, a[12:0]} & rmask[18:0];
                     r.write   = is_wr;
                  end else if (!is_wr) begin
                     r.read_zero = 1'b1;
                  end
               end else if (!is_wr) begin
                  r.target  = cbm_pkg::TGT_PRG_ROM;
                  r.address = {bank & cfg_prg_mask, a[12:0]};
               end
            end else if (a >= 16'h8000) begin
               if (is_wr) begin
                  if (a < 16'hA000) cmd_sel = d[3:0];
                  else if (a < 16'hC000) load_command(d);
               end else begin
                  bank = (a[14:13] < 2'd3) ? prg_bk[a[14:13]] : cbm_pkg::FIXED_PRG_BANK;
                  r.target  = cbm_pkg::TGT_PRG_ROM;
                  r.address = {bank & cfg_prg_mask, a[12:0]};
               end
            end
         end
         cbm_pkg::MODE_PPU_READ, cbm_pkg::MODE_PPU_WRITE: begin
            if (a < 16'h2000) begin
               cbank = chr_bk[a[12:10]] & cfg_chr_mask;
               if (cfg_chr_ram) begin
                  r.target  = cbm_pkg::TGT_CHR_RAM;
                  r.address = {1'b0, cbank, a[9:0]};
                  r.write   = (m == cbm_pkg::MODE_PPU_WRITE);
               end else if (m == cbm_pkg::MODE_PPU_READ) begin
                  r.target  = cbm_pkg::TGT_CHR_ROM;
                  r.address = {1'b0, cbank, a[9:0]};
               end
            end
         end
         cbm_pkg::MODE_TICK: begin
            if (cnt_en) begin
               prev = irq_cnt;
               irq_cnt = irq_cnt - 16'd1;
               if (prev == 16'd0 && irq_en && !irq_pend) irq_pend = 1'b1;
            end
         end
         default: ;
      endcase
      r.irq       = irq_pend;
      r.mirroring = mirror;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch on word %0d, %s: expected %0h, got %0h",
               words_checked, what, want, got);
      mismatches++;
   endtask

   // accepted request words
   always @(posedge clock) begin
      word_type predicted;
      if (!reset && req_valid && req_ready) begin
         map_bus_event(req_mode, req_bus_address, req_write_data, predicted);
         pending_words.push_back(row_fixed ? row_want : predicted);
      end
   end

   // accepted response words
   always @(posedge clock) begin
      word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("word with nothing pending", 32'd0, 32'd0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_mem_target !== want.target)
               report_mismatch("mem_target", 32'(want.target), 32'(rsp_mem_target));
            if (rsp_mem_address !== want.address)
               report_mismatch("mem_address", 32'(want.address), 32'(rsp_mem_address));
            if (rsp_mem_write !== want.write)
               report_mismatch("mem_write", 32'(want.write), 32'(rsp_mem_write));
            if (rsp_read_zero !== want.read_zero)
               report_mismatch("read_zero", 32'(want.read_zero), 32'(rsp_read_zero));
            if (rsp_irq_line !== want.irq)
               report_mismatch("irq_line", 32'(want.irq), 32'(rsp_irq_line));
            if (rsp_mirroring !== want.mirroring)
               report_mismatch("mirroring", 32'(want.mirroring), 32'(rsp_mirroring));
         end
         if (rsp_irq_line === 1'b1) irq_words++;
         words_checked++;
      end
   end

   // receiver, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_request <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic push_word(input logic [2:0] m, input logic [15:0] a, input logic [7:0] d,
                            input logic fixed, input word_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= m;
      req_bus_address <= a;
      req_write_data  <= d;
      row_fixed       <= fixed;
      row_want        <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      while (pending_words.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_sizes(input logic [5:0] pm, input logic [7:0] cm,
                                input logic cr, input logic [4:0] rl);
      logic [7:0] vals [4];
      vals = '{{2'b0, pm}, cm, {7'b0, cr}, {3'b0, rl}};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= cbm_pkg::csr_index_type'(i);
         csr_write_data   <= vals[i];
         @(posedge clock);
         case (cbm_pkg::csr_index_type'(i))
            cbm_pkg::CSR_PRG_ROM_MASK: cfg_prg_mask = vals[i][5:0];
            cbm_pkg::CSR_CHR_MASK:     cfg_chr_mask = vals[i];
            cbm_pkg::CSR_CHR_IS_RAM:   cfg_chr_ram  = vals[i][0];
            cbm_pkg::CSR_PRG_RAM_LOG2: cfg_ram_log2 = vals[i][4:0];
         endcase
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
      settings_run++;
   endtask

   task automatic run_random(input int quota);
      int          sent;
      int          n;
      int          pick;
      logic [3:0]  c;
      logic [7:0]  d;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(99) < 10) begin
            push_word(3'($urandom_range(7)), 16'($urandom), 8'($urandom), 1'b0, QUIET);
            sent++;
         end else begin
            c = 4'($urandom_range(15));
            d = 8'($urandom);
            if (c == cbm_pkg::CMD_COUNT_LO) d = 8'($urandom_range(8));
            else if (c == cbm_pkg::CMD_COUNT_HI && $urandom_range(3) != 0) d = 8'h00;
            else if ((c == cbm_pkg::CMD_IRQ_CTRL || c == cbm_pkg::CMD_WINDOW) &&
                     $urandom_range(3) != 0)
               d = d | ((c == cbm_pkg::CMD_WINDOW) ? 8'h80 : 8'h81);
            push_word(cbm_pkg::MODE_CPU_WRITE, 16'h8000 + 16'($urandom_range(16'h1FFF)),
                      {4'($urandom), c}, 1'b0, QUIET);
            sent++;
            // an occasional select is left without its load
            if ($urandom_range(9) != 0) begin
               push_word(cbm_pkg::MODE_CPU_WRITE, 16'hA000 + 16'($urandom_range(16'h1FFF)),
                         d, 1'b0, QUIET);
               sent++;
            end
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
               pick = $urandom_range(99);
               if (pick < 30)
                  push_word(cbm_pkg::MODE_TICK, 16'($urandom), 8'($urandom), 1'b0, QUIET);
               else if (pick < 50)
                  push_word(cbm_pkg::MODE_CPU_READ, 16'h6000 + 16'($urandom_range(16'h9FFF)),
                            8'($urandom), 1'b0, QUIET);
               else if (pick < 62)
                  push_word(cbm_pkg::MODE_CPU_WRITE, 16'h6000 + 16'($urandom_range(16'h1FFF)),
                            8'($urandom), 1'b0, QUIET);
               else if (pick < 81)
                  push_word(cbm_pkg::MODE_PPU_READ, 16'($urandom_range(16'h1FFF)),
                            8'($urandom), 1'b0, QUIET);
               else
                  push_word(cbm_pkg::MODE_PPU_WRITE, 16'($urandom_range(16'h1FFF)),
                            8'($urandom), 1'b0, QUIET);
               sent++;
            end
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [5:0] pm, input logic [7:0] cm, input logic cr,
                            input logic [4:0] rl, input int sp, input int rp,
                            input logic squeeze);
      drain();
      program_sizes(pm, cm, cr, rl);
      send_idle_pct = sp;
      recv_idle_pct = rp;
      if (squeeze) hold_request <= 1'b1;
      run_random(PHASE_WORDS);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset_mapper_model();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 16;
      recv_idle_pct = 58;
      for (int i = 0; i < SCRIPT_ROWS; i++)
         push_word(script[i].mode, script[i].address, script[i].data, script[i].fixed,
                   script[i].want);
      req_valid <= 1'b0;

      run_phase(6'd63, 8'd255, 1'b0, 5'd13, 16, 58, 1'b1);
      run_phase(6'd0,  8'd0,   1'b1, 5'd0,  16, 58, 1'b0);
      run_phase(6'd7,  8'd31,  1'b1, 5'd19, 58, 16, 1'b1);
      run_phase(6'd15, 8'd127, 1'b0, 5'd31, 58, 16, 1'b0);
      run_phase(6'((1 << $urandom_range(6)) - 1), 8'((1 << $urandom_range(8)) - 1),
                1'($urandom), 5'($urandom_range(31)), 0, 0, 1'b0);

      drain();
      repeat (8) @(posedge clock);
      $display("checked %0d response words: directed table plus %0d size settings",
               words_checked, settings_run);
      $display("irq line seen high on %0d words, %0d mismatches", irq_words, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
